@@ sv/logistic_regression_gradient_defines.svh @@
// ---------------------------------------------------------------------------
// logistic_regression_gradient assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef LOGISTIC_REGRESSION_GRADIENT_DEFINES_SVH
`define LOGISTIC_REGRESSION_GRADIENT_DEFINES_SVH

`ifndef SYNTHESIS

`define LRG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`define LRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`else

`define LRG_ASSERT_IMPL(label, clk, rst, ante, cons)

`define LRG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/lrg_pkg.sv @@
// ---------------------------------------------------------------------------
// lrg_pkg
// shared widths and types of the logistic regression gradient pipeline
// ---------------------------------------------------------------------------
package lrg_pkg;

  localparam int NUM_FEATURES = 4;
  localparam int FEAT_W       = 16;
  localparam int PROB_W       = 16;
  localparam int GRAD_W       = 32;
  localparam int ERR_W        = PROB_W + 1;
  localparam int PROD_W       = 2 * FEAT_W;
  localparam int Z_W          = PROD_W + 2;
  localparam int Z_SHIFT      = 12;
  localparam int CFG_INDEX_W  = 8;

  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef logic        [PROB_W-1:0] prob_t;
  typedef logic        [PROB_W-1:0] sig_t;
  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [Z_W-1:0]    z_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [CFG_INDEX_W-1:0]   cfg_index_t;

endpackage

@@ sv/lrg_sigmoid_rom.sv @@
// ---------------------------------------------------------------------------
// lrg_sigmoid_rom
// constant sigmoid table in Q0.16, built at elaboration, registered read
// ---------------------------------------------------------------------------
module lrg_sigmoid_rom #(
  parameter int ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [$clog2(ENTRIES)-1:0] addr,
  output lrg_pkg::sig_t              data
);
  import lrg_pkg::*;

  localparam int HALF = ENTRIES / 2;
  localparam logic [63:0] DECAY_Q32 = 64'd4034748382;
  localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [64:0] RND_Q32   = 65'h0_8000_0000;

  function automatic sig_t sig_entry(input int k, input int half);
    int          m;
    int          mag;
    logic [63:0] p;
    logic [64:0] prod;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] nn;
    logic [63:0] dd;
    logic [63:0] r;
    logic [63:0] q;
    m   = k - half;
    mag = (m < 0) ? -m : m;
    p   = ONE_Q32;
    for (int i = 0; i < mag; i++) begin
      prod = {1'b0, p} * {1'b0, DECAY_Q32};
      prod = prod + RND_Q32;
      p    = prod[63:0] >> 32;
      p    = p | (64'(prod[64]) << 32);
    end
    den = ONE_Q32 + p;
    if (m >= 0) begin
      num = 64'd65535 * ONE_Q32;
    end else begin
      num = 64'd65535 * p;
    end
    nn = (num << 1) + den;
    dd = den << 1;
    r  = '0;
    q  = '0;
    // restoring long division
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], nn[b]};
      if (r >= dd) begin
        r    = r - dd;
        q[b] = 1'b1;
      end
    end
    return q[PROB_W-1:0];
  endfunction

  sig_t rom [ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
    localparam sig_t VAL = sig_entry(k, HALF);
    assign rom[k] = VAL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

@@ sv/logistic_regression_gradient.sv @@
// ---------------------------------------------------------------------------
// logistic_regression_gradient: gradient of the logistic loss per sample
// takes one sample per cycle while out_ready does not hold back the pipeline
// stages: multiply, sum, table index, sigmoid read, error, gradient multiply
// synchronous reset clears all stage valids and sets the weights to zero
// ---------------------------------------------------------------------------
`include "logistic_regression_gradient_defines.svh"

module logistic_regression_gradient #(
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lrg_pkg::feat_t         feature_0,
  input  lrg_pkg::feat_t         feature_1,
  input  lrg_pkg::feat_t         feature_2,
  input  lrg_pkg::feat_t         feature_3,
  input  lrg_pkg::prob_t         target_prob,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lrg_pkg::grad_t         grad_0,
  output lrg_pkg::grad_t         grad_1,
  output lrg_pkg::grad_t         grad_2,
  output lrg_pkg::grad_t         grad_3,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  lrg_pkg::cfg_index_t    cfg_index,
  input  lrg_pkg::feat_t         cfg_data
);
  import lrg_pkg::*;

  localparam int NSTG   = 6;
  localparam int IDX_W  = $clog2(SIGMOID_ENTRIES);
  localparam int WSEL_W = $clog2(NUM_FEATURES);
  localparam z_t HALF_Z = Z_W'(SIGMOID_ENTRIES / 2);
  localparam z_t MAX_Z  = Z_W'(SIGMOID_ENTRIES - 1);

  // configuration
  feat_t weight [NUM_FEATURES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FEATURES; i++) begin
        weight[i] <= '0;
      end
    end else if (cfg_valid && cfg_index < CFG_INDEX_W'(NUM_FEATURES)) begin
      weight[cfg_index[WSEL_W-1:0]] <= cfg_data;
    end
  end

  // stage handshake
  logic [NSTG-1:0] v;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !v[NSTG-1] || out_ready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (rdy[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  feat_t feat_in [NUM_FEATURES];

  assign feat_in[0] = feature_0;
  assign feat_in[1] = feature_1;
  assign feat_in[2] = feature_2;
  assign feat_in[3] = feature_3;

  // payload
  feat_t     feat_p [NSTG-1][NUM_FEATURES];
  prob_t     tgt_p  [4];
  prod_t     prod0  [NUM_FEATURES];
  z_t        z1;
  logic [IDX_W-1:0] idx2;
  sig_t      sig3;
  err_t      err4;
  grad_t     grad5  [NUM_FEATURES];

  z_t zsum;
  z_t zsh;
  z_t zidx;

  always_comb begin
    zsum = '0;
    for (int i = 0; i < NUM_FEATURES; i++) begin
      zsum = zsum + Z_W'(prod0[i]);
    end
  end

  // floor(z * 16) is an arithmetic shift of the Q.16 sum
  always_comb begin
    zsh  = z1 >>> Z_SHIFT;
    zidx = zsh + HALF_Z;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < NUM_FEATURES; i++) begin
        prod0[i]     <= weight[i] * feat_in[i];
        feat_p[0][i] <= feat_in[i];
      end
      tgt_p[0] <= target_prob;
    end
    for (int s = 1; s < NSTG - 1; s++) begin
      if (rdy[s]) begin
        feat_p[s] <= feat_p[s-1];
      end
    end
    for (int s = 1; s < 4; s++) begin
      if (rdy[s]) begin
        tgt_p[s] <= tgt_p[s-1];
      end
    end
    if (rdy[1]) begin
      z1 <= zsum;
    end
    if (rdy[2]) begin
      if (zidx < 0) begin
        idx2 <= '0;
      end else if (zidx > MAX_Z) begin
        idx2 <= MAX_Z[IDX_W-1:0];
      end else begin
        idx2 <= zidx[IDX_W-1:0];
      end
    end
    if (rdy[4]) begin
      err4 <= $signed({1'b0, sig3}) - $signed({1'b0, tgt_p[3]});
    end
    if (rdy[5]) begin
      for (int i = 0; i < NUM_FEATURES; i++) begin
        grad5[i] <= GRAD_W'(err4 * feat_p[4][i]);
      end
    end
  end

  lrg_sigmoid_rom #(
    .ENTRIES (SIGMOID_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .en   (rdy[3]),
    .addr (idx2),
    .data (sig3)
  );

  assign grad_0 = grad5[0];
  assign grad_1 = grad5[1];
  assign grad_2 = grad5[2];
  assign grad_3 = grad5[3];

  `LRG_ASSERT_NEXT(a_in_enters, clk, rst, in_valid && in_ready, v[0])
  `LRG_ASSERT_NEXT(a_weight_write, clk, rst, cfg_valid && cfg_index == '0, weight[0] == $past(cfg_data))
  `LRG_ASSERT_IMPL(a_idx_range, clk, rst, v[3], $past(idx2) <= MAX_Z[IDX_W-1:0] || !$past(rdy[3]))
  `LRG_ASSERT_NEXT(a_out_stall, clk, rst, out_valid && !out_ready, out_valid && v[NSTG-1] == $past(v[NSTG-1]))

endmodule

@@ tb/logistic_regression_gradient_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// logistic_regression_gradient_checker
// watches the weight, sample and gradient channels of the block, computes the
// expected gradients of every accepted sample from its own weight copy and
// sigmoid table, and compares them in order with the gradient transactions
// ---------------------------------------------------------------------------
module logistic_regression_gradient_checker #(
  parameter int TABLE_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lrg_pkg::feat_t      feature_0,
  input  lrg_pkg::feat_t      feature_1,
  input  lrg_pkg::feat_t      feature_2,
  input  lrg_pkg::feat_t      feature_3,
  input  lrg_pkg::prob_t      target_prob,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lrg_pkg::grad_t      grad_0,
  input  lrg_pkg::grad_t      grad_1,
  input  lrg_pkg::grad_t      grad_2,
  input  lrg_pkg::grad_t      grad_3,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  lrg_pkg::cfg_index_t cfg_index,
  input  lrg_pkg::feat_t      cfg_data,
  output int                  mismatch_count,
  output int                  results_pending
);
  import lrg_pkg::*;

  typedef logic [NUM_FEATURES-1:0][FEAT_W-1:0] feat_vec_t;
  typedef logic [NUM_FEATURES-1:0][GRAD_W-1:0] grad_vec_t;

  sig_t      sigmoid_lut [TABLE_SIZE];
  feat_t     weights [NUM_FEATURES];
  grad_vec_t gradient_queue [$];
  int        fail_total = 0;
  int        queued = 0;

  assign mismatch_count  = fail_total;
  assign results_pending = queued;

  // exp(-1/16) and one in 32-bit fraction fixed point
  function automatic sig_t sigmoid_entry(int k);
    longint unsigned decay = 64'd4034748382;
    longint unsigned one   = 64'h1_0000_0000;
    longint unsigned p;
    longint unsigned num;
    longint unsigned den;
    int              m;
    int              mag;
    m   = k - TABLE_SIZE / 2;
    mag = (m < 0) ? -m : m;
    p   = one;
    for (int i = 0; i < mag; i++) begin
      p = (p * decay + 64'h8000_0000) >> 32;
    end
    den = one + p;
    num = (m >= 0) ? 64'd65535 * one : 64'd65535 * p;
    return sig_t'((2 * num + den) / (2 * den));
  endfunction

  function automatic grad_vec_t predict_gradients(feat_vec_t feats, prob_t target);
    longint    z;
    longint    idx;
    longint    err;
    grad_vec_t g;
    z = 0;
    for (int i = 0; i < NUM_FEATURES; i++) begin
      z += longint'(weights[i]) * longint'($signed(feats[i]));
    end
    idx = (z >>> Z_SHIFT) + TABLE_SIZE / 2;
    if (idx < 0) idx = 0;
    if (idx > TABLE_SIZE - 1) idx = TABLE_SIZE - 1;
    err = longint'(sigmoid_lut[idx]) - longint'(target);
    for (int i = 0; i < NUM_FEATURES; i++) begin
      g[i] = GRAD_W'(err * longint'($signed(feats[i])));
    end
    return g;
  endfunction

  initial begin
    for (int k = 0; k < TABLE_SIZE; k++) begin
      sigmoid_lut[k] = sigmoid_entry(k);
    end
  end

  always @(posedge clk) begin
    grad_vec_t want;
    grad_vec_t seen;
    if (rst) begin
      for (int i = 0; i < NUM_FEATURES; i++) begin
        weights[i] = '0;
      end
      gradient_queue.delete();
    end else begin
      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        seen = {grad_3, grad_2, grad_1, grad_0};
        if (gradient_queue.size() == 0) begin
          $error("gradient transaction with no sample outstanding");
          fail_total++;
        end else begin
          want = gradient_queue.pop_front();
          for (int i = 0; i < NUM_FEATURES; i++) begin
            if (seen[i] !== want[i]) begin
              $error("grad_%0d mismatch: expected %0d, actual %0d",
                     i, $signed(want[i]), $signed(seen[i]));
              fail_total++;
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        gradient_queue.insert(gradient_queue.size(), predict_gradients(
          {feature_3, feature_2, feature_1, feature_0}, target_prob));
      end
      // writes outside the weight list are dropped
      if (cfg_valid && cfg_ready && cfg_index < NUM_FEATURES) begin
        weights[cfg_index] = cfg_data;
      end
    end
    queued = gradient_queue.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives weight writes and samples into logistic_regression_gradient with
// random idle bursts on samples and gradients, one long output hold, sweeping
// the sigmoid index range and weight extremes; the checker does the comparing
// ---------------------------------------------------------------------------
module testbench;
  import lrg_pkg::*;

  localparam cfg_index_t WEIGHT_0_REG    = 8'd0;
  localparam cfg_index_t WEIGHT_1_REG    = 8'd1;
  localparam cfg_index_t WEIGHT_2_REG    = 8'd2;
  localparam cfg_index_t WEIGHT_3_REG    = 8'd3;
  localparam cfg_index_t SPARE_REG_FIRST = 8'd4;
  localparam cfg_index_t SPARE_REG_LAST  = 8'd255;

  localparam int PHASES          = 6;
  localparam int SAMPLES_PER_RUN = 150;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_CYCLES    = 10;
  localparam int CYCLE_LIMIT     = 500000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  feat_t      feature_0;
  feat_t      feature_1;
  feat_t      feature_2;
  feat_t      feature_3;
  prob_t      target_prob;
  logic       out_valid;
  logic       out_ready;
  grad_t      grad_0;
  grad_t      grad_1;
  grad_t      grad_2;
  grad_t      grad_3;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_index_t cfg_index;
  feat_t      cfg_data;

  int   mismatch_count;
  int   results_pending;
  int   cycle_count = 0;
  logic send_gaps = 1'b1;
  logic sink_gaps = 1'b1;
  logic hold_request = 1'b0;

  logistic_regression_gradient i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .feature_0  (feature_0),
    .feature_1  (feature_1),
    .feature_2  (feature_2),
    .feature_3  (feature_3),
    .target_prob(target_prob),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .grad_0     (grad_0),
    .grad_1     (grad_1),
    .grad_2     (grad_2),
    .grad_3     (grad_3),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  logistic_regression_gradient_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .feature_0      (feature_0),
    .feature_1      (feature_1),
    .feature_2      (feature_2),
    .feature_3      (feature_3),
    .target_prob    (target_prob),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .grad_0         (grad_0),
    .grad_1         (grad_1),
    .grad_2         (grad_2),
    .grad_3         (grad_3),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL logistic_regression_gradient");
    $finish;
  end

  // gradient sink: random hold bursts, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready = 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) begin
          @(negedge clk);
        end
      end else if (sink_gaps && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  function automatic feat_t random_feature();
    case ($urandom_range(0, 3))
      0: return feat_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return feat_t'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  function automatic feat_t small_weight();
    return feat_t'($signed($urandom_range(0, 128)) - 64);
  endfunction

  function automatic prob_t random_target();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return prob_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(feat_t f0, feat_t f1, feat_t f2, feat_t f3, prob_t target);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid    = 1'b1;
    feature_0   = f0;
    feature_1   = f1;
    feature_2   = f2;
    feature_3   = f3;
    target_prob = target;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // leaves cfg_valid high so a group of writes goes back to back
  task automatic write_reg(cfg_index_t idx, feat_t value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_weights(feat_t w0, feat_t w1, feat_t w2, feat_t w3);
    write_reg(WEIGHT_0_REG, w0);
    write_reg(WEIGHT_1_REG, w1);
    write_reg(WEIGHT_2_REG, w2);
    write_reg(WEIGHT_3_REG, w3);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    wait (results_pending == 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    feature_0   = '0;
    feature_1   = '0;
    feature_2   = '0;
    feature_3   = '0;
    target_prob = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset weights give z of zero
    send_sample(16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 16'h0000);

    // z = f0 + 4096 * f1 - 32768 * f2 + 32767 * f3 walks the table edges
    wait_drained();
    load_weights(16'sd1, 16'sd4096, -16'sd32768, 16'sd32767);
    send_sample(16'sd0,      16'sd0,      16'sd0, 16'sd0, 16'h0000);
    send_sample(-16'sd1,     16'sd0,      16'sd0, 16'sd0, 16'hffff);
    send_sample(16'sd4095,   16'sd0,      16'sd0, 16'sd0, 16'h8000);
    send_sample(16'sd4096,   16'sd0,      16'sd0, 16'sd0, 16'h7fff);
    send_sample(16'sd0,      -16'sd128,   16'sd0, 16'sd0, 16'h0000);
    send_sample(-16'sd1,     -16'sd128,   16'sd0, 16'sd0, 16'hffff);
    send_sample(16'sd4095,   16'sd127,    16'sd0, 16'sd0, 16'h0000);
    send_sample(16'sd0,      16'sd128,    16'sd0, 16'sd0, 16'hffff);
    send_sample(16'sd0,      16'sh8000,   16'sd0, 16'sd0, 16'h1234);
    send_sample(16'sd0,      16'sh7fff,   16'sd0, 16'sd0, 16'hedcb);
    send_sample(16'sd0,      16'sd0,      16'sd1, 16'sd0, 16'h0001);
    send_sample(16'sd0,      16'sd0,      16'sh8000, 16'sd0, 16'h0000);
    send_sample(16'sd0,      16'sd0,      16'sd0, 16'sh8000, 16'hffff);
    send_sample(16'sh7fff,   16'sh7fff,   16'sh7fff, 16'sh7fff, 16'h0000);
    send_sample(16'sh8000,   16'sh8000,   16'sh8000, 16'sh8000, 16'hffff);
    send_sample(16'sh7fff,   16'sh8000,   16'sh7fff, 16'sh8000, 16'h3039);
    send_sample(16'sh8000,   16'sh7fff,   16'sh8000, 16'sh7fff, 16'h0000);
    send_sample(16'sh5555,   16'shaaaa,   16'sh5555, 16'shaaaa, 16'h5555);
    send_sample(16'shaaaa,   16'sh5555,   16'shaaaa, 16'sh5555, 16'haaaa);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: load_weights(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        1: load_weights(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        3: begin
          load_weights(feat_t'($urandom), feat_t'($urandom),
                       feat_t'($urandom), feat_t'($urandom));
          // out-of-range indexes must leave the weights alone
          write_reg(SPARE_REG_FIRST, 16'sh7fff);
          write_reg(SPARE_REG_LAST, 16'sh8000);
          cfg_valid = 1'b0;
        end
        4: load_weights(16'sh7fff, 16'sh8000, 16'sh0000, small_weight());
        default: load_weights(small_weight(), small_weight(),
                              small_weight(), small_weight());
      endcase
      if (phase == PHASES - 1) begin
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
      end
      for (int k = 0; k < SAMPLES_PER_RUN; k++) begin
        if (phase == 2 && k == 5) begin
          // back up the pipeline behind a long output hold
          hold_request = 1'b1;
          send_gaps    = 1'b0;
        end
        if (phase == 2 && k == 60) begin
          send_gaps = 1'b1;
        end
        send_sample(random_feature(), random_feature(), random_feature(),
                    random_feature(), random_target());
      end
    end

    in_valid = 1'b0;
    wait (results_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("PASS logistic_regression_gradient");
    end else begin
      $display("FAIL logistic_regression_gradient");
    end
    $finish;
  end

endmodule
